>>> hdl/sst_pkg.sv
// Shared types and constants for the sorted set table.
// No dependencies; imported by every module of the block.
`default_nettype none

package sst_pkg;

    localparam int SST_CAPACITY = 64;

    // APB address width and the register index of the order bit.
    localparam int  ADDR_W         = 3;
    localparam logic REG_ORDER_DESC = 1'b0;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SHIFT_NONE = 2'd0,
        SHIFT_INS  = 2'd1,
        SHIFT_DEL  = 2'd2
    } shift_op_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SRCH = 1'b1
    } state_t;

endpackage

`default_nettype wire

>>> hdl/sst_cell.sv
// One storage cell of the sorted set table: holds one entry, compares it
// against the probe value and shifts with its neighbors. Depends on sst_pkg.
`default_nettype none

module sst_cell
    import sst_pkg::*;
#(
    parameter int IW  = 6,
    parameter int IDX = 0
)(
    input  wire logic            clk,
    input  wire logic            compare_en,
    input  wire logic [31:0]     probe,
    input  wire logic            order_desc,
    input  wire shift_op_t       shift_op,
    input  wire logic [IW-1:0]   shift_pos,
    input  wire logic [31:0]     key,
    input  wire logic [31:0]     left_data,
    input  wire logic [31:0]     right_data,
    output logic      [31:0]     entry,
    output logic                 eq,
    output logic                 bef
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [31:0] entry_reg, entry_next;
    logic        eq_reg, eq_next;
    logic        bef_reg, bef_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (shift_op)
            SHIFT_INS:
            begin
                if (MY_IDX > shift_pos)
                    entry_next = left_data;
                else if (MY_IDX == shift_pos)
                    entry_next = key;
            end
            SHIFT_DEL:
            begin
                if (MY_IDX >= shift_pos)
                    entry_next = right_data;
            end
            default: entry_next = entry_reg;
        endcase
    end

    // Probe goes before entry under the current order.
    always_comb
    begin
        eq_next  = eq_reg;
        bef_next = bef_reg;
        if (compare_en)
        begin
            eq_next  = (probe == entry_reg);
            bef_next = order_desc ? ($signed(probe) > $signed(entry_reg))
                                  : ($signed(probe) < $signed(entry_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        eq_reg    <= eq_next;
        bef_reg   <= bef_next;
    end

    assign entry = entry_reg;
    assign eq    = eq_reg;
    assign bef   = bef_reg;

endmodule

`default_nettype wire

>>> hdl/sst_search.sv
// Binary search walker: one probe per cycle while active, over the registered
// compare bits of the cell row. Depends on sst_pkg.
`default_nettype none

module sst_search
    import sst_pkg::*;
#(
    parameter int CAPACITY = SST_CAPACITY
)(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire logic                               active,
    input  wire logic [$clog2(CAPACITY+1)-1:0]      count,
    input  wire logic [CAPACITY-1:0]                eq_vec,
    input  wire logic [CAPACITY-1:0]                bef_vec,
    output logic                                    done,
    output logic                                    found,
    output logic      [$clog2(CAPACITY+1)-1:0]      pos
);

    localparam int CW = $clog2(CAPACITY+1);
    localparam int IW = $clog2(CAPACITY);

    // Upper bound is kept as right + 1 so it never goes negative.
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] rp1_reg, rp1_next;
    logic [CW:0]   sum;
    logic [CW-1:0] mid;
    logic [IW-1:0] mid_idx;
    logic          in_range;
    logic          hit;

    always_comb
    begin
        in_range = (left_reg < rp1_reg);
        sum      = {1'b0, left_reg} + {1'b0, rp1_reg} - {{CW{1'b0}}, 1'b1};
        mid      = sum[CW:1];
        mid_idx  = mid[IW-1:0];
        hit      = in_range && eq_vec[mid_idx];
        done     = !in_range || hit;
        found    = hit;
        pos      = hit ? mid : left_reg;

        left_next = left_reg;
        rp1_next  = rp1_reg;
        if (load)
        begin
            left_next = '0;
            rp1_next  = count;
        end
        else if (active && in_range && !hit)
        begin
            if (bef_vec[mid_idx])
                rp1_next = mid;
            else
                left_next = mid + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            rp1_reg  <= '0;
        end
        else
        begin
            left_reg <= left_next;
            rp1_reg  <= rp1_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/sorted_set_table.sv
// Top level of the sorted set table: command channel, APB register, cell
// row and search walker. Depends on sst_pkg, sst_cell and sst_search.
//
//   channel   signals                               direction  beat taken when
//   --------  ------------------------------------  ---------  --------------------------
//   command   start, busy, cmd, value               in         start && !busy at clk rise
//   result    done, status, item_count, is_empty    out        done high (one cycle)
//   config    psel, penable, pwrite, paddr,         in/out     psel && penable && pwrite
//             pwdata, prdata, pready                           (pready is tied high)
//
// The accept edge latches the probe compares in every cell at once.
// The walker then makes one binary search probe per cycle over those compare
// bits, and the block stays busy until a probe hits or, when the value is
// absent, until the search range is empty; the shift of the cell row happens
// on the edge that ends the search, together with the count update.
// The result beat shows in the following cycle, while the next command may
// already be accepted. Reset empties the set (count zero) and selects
// ascending order; the entries themselves are not cleared. The receiver
// cannot stall: every result beat is taken in its single cycle.
`default_nettype none

module sorted_set_table
    import sst_pkg::*;
#(
    parameter int CAPACITY = SST_CAPACITY
)(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command channel
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     cmd,
    input  wire logic signed [31:0]             value,
    // result channel
    output logic                                done,
    output logic      [1:0]                     status,
    output logic      [$clog2(CAPACITY+1)-1:0]  item_count,
    output logic                                is_empty,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ADDR_W-1:0]              paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);

    localparam int CW = $clog2(CAPACITY+1);
    localparam int IW = $clog2(CAPACITY);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic          order_reg, order_next;
    logic [1:0]    cmd_reg;
    logic [31:0]   key_reg;

    logic          accept;
    logic          cfg_write;
    shift_op_t     shift_op;
    logic [IW-1:0] shift_pos;

    logic [31:0]          entry_w [CAPACITY];
    logic [CAPACITY-1:0]  eq_vec;
    logic [CAPACITY-1:0]  bef_vec;

    logic          srch_done;
    logic          srch_found;
    logic [CW-1:0] srch_pos;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Register file: one bit, index taken from the word address.
    always_comb
    begin
        order_next = order_reg;
        if (cfg_write && (paddr[2] == REG_ORDER_DESC))
            order_next = pwdata[0];
    end

    assign prdata = (paddr[2] == REG_ORDER_DESC) ? {31'b0, order_reg} : 32'b0;

    // Row of cells; each hands its entry to the neighbors it has.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [31:0] left_d;
        logic [31:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = key_reg;
        end
        else
        begin : g_left
            assign left_d = entry_w[i-1];
        end

        if (i == CAPACITY-1)
        begin : g_last
            assign right_d = entry_w[i];
        end
        else
        begin : g_right
            assign right_d = entry_w[i+1];
        end

        sst_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .compare_en (accept),
            .probe      (value),
            .order_desc (order_reg),
            .shift_op   (shift_op),
            .shift_pos  (shift_pos),
            .key        (key_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .entry      (entry_w[i]),
            .eq         (eq_vec[i]),
            .bef        (bef_vec[i])
        );
    end

    sst_search #(
        .CAPACITY (CAPACITY)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .active  (state_reg == S_SRCH),
        .count   (count_reg),
        .eq_vec  (eq_vec),
        .bef_vec (bef_vec),
        .done    (srch_done),
        .found   (srch_found),
        .pos     (srch_pos)
    );

    // Sequencer: wait for the walker, then apply the shift and post the beat.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        shift_op    = SHIFT_NONE;
        shift_pos   = srch_pos[IW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_SRCH;
            end
            S_SRCH:
            begin
                if (srch_done)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            // duplicate check comes before the full check
                            if (srch_found)
                                status_next = ST_MISS;
                            else if (count_reg >= CW'(CAPACITY))
                                status_next = ST_FULL;
                            else
                            begin
                                status_next = ST_OK;
                                shift_op    = SHIFT_INS;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!srch_found)
                                status_next = ST_MISS;
                            else
                            begin
                                status_next = ST_OK;
                                shift_op    = SHIFT_DEL;
                                count_next  = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            // search, and the unused code behaves as one
                            status_next = srch_found ? ST_OK : ST_MISS;
                        end
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            order_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            order_reg <= order_next;
        end
    end

    // Command payload and result status carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            key_reg <= value;
        end
        status_reg <= status_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign item_count = count_reg;
    assign is_empty   = (count_reg == '0);

    // A result beat only follows the final search cycle.
    a_done_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_SRCH))
        else $error("result beat without a finished search");

    // The held count never passes capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("held count above capacity");

    // An accepted command keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a command");

    // A successful add grows the count by exactly one.
    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_OK && cmd_reg == CMD_ADD)
            |-> (count_reg == CW'($past(count_reg) + CW'(1))))
        else $error("successful add did not advance the count");

    // A refused command leaves the count untouched.
    a_miss_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (count_reg == $past(count_reg)))
        else $error("refused command changed the count");

endmodule

`default_nettype wire
